FILE: design/multi_input_debounce_toggle_assert.svh
// assertion macros for the multi-input debounce and toggle block
// no dependencies; included by the rtl files that carry assertions
`ifndef MULTI_INPUT_DEBOUNCE_TOGGLE_ASSERT_SVH
`define MULTI_INPUT_DEBOUNCE_TOGGLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property on an explicit clock and reset
`define MIDT_ASSERT_CR(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("midt assertion failed");
// property on the usual clk and rst of the module
`define MIDT_ASSERT(label, prop) \
  `MIDT_ASSERT_CR(label, clk, rst, prop)
`else
`define MIDT_ASSERT_CR(label, clk_s, rst_s, prop)
`define MIDT_ASSERT(label, prop)
`endif
`endif

FILE: design/midt_pkg.sv
// shared constants and types for the multi-input debounce and toggle block
// no dependencies
`default_nettype none

package midt_pkg;

  localparam int CHAN_MAX          = 16;
  localparam int TICK_W            = 16;
  localparam int DEF_NUM_CHANNELS  = 16;
  localparam int DEF_CLICK_CHANGES = 2;
  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd50;
  localparam logic [TICK_W-1:0] ELAPSED_MAX = 16'hFFFF;

  // per-channel state word held in the state memory
  typedef struct packed {
    logic              count;
    logic              running;
    logic [TICK_W-1:0] elapsed;
  } chan_state_t;

endpackage

`default_nettype wire

FILE: design/multi_input_debounce_toggle.sv
// multi-input debounce and toggle block, top level
// depends on midt_pkg and multi_input_debounce_toggle_assert.svh
`default_nettype none
`include "multi_input_debounce_toggle_assert.svh"

// Each input beat is one tick: a raw sample of all inputs (tdata) and the
// manual-mode flag (tuser). Every channel runs its own timer; a change held
// for debounce_ticks ticks is committed to the debounced vector, and in manual
// mode every second committed change (or every one, with CLICK_CHANGES = 1)
// flips the channel's clicked bit. Each input beat gives one output beat with
// the debounced vector in tdata[15:0] and the clicked vector in tdata[31:16].
// Per-channel timer state lives in a simple dual-port state memory (one read
// and one write each cycle) with a registered read; channels are swept one per
// clock while the sweep is not stalled, so a beat holds the block until its
// last channel is issued. The next beat is taken on the same cycle that the
// last channel of the current one is issued, so a new beat can enter while
// the current one is still in stage one; its result passes from stage one
// into the output register, and a waiting output beat stalls the sweep only
// when the next result is ready to replace it. The state memory has
// per-entry valid bits cleared by reset, so there is no clearing pass.
// debounce_ticks resets to 50 and should be written only while idle.
module multi_input_debounce_toggle #(
  parameter int NUM_CHANNELS  = midt_pkg::DEF_NUM_CHANNELS,
  parameter int CLICK_CHANGES = midt_pkg::DEF_CLICK_CHANGES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,      // debounce_ticks
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // raw_inputs[15:0]
  input  wire logic        s_axis_tuser,   // manual_mode
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // debounced_inputs[15:0], clicked_inputs[31:16]
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [1:0] CLICK_N = 2'(CLICK_CHANGES);

  // configuration register
  logic [midt_pkg::TICK_W-1:0] debounce_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= midt_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      debounce_ticks <= cfg_wdata;
    end
  end

  // held input beat and channel sweep counter
  logic                          busy;
  logic [CH_W-1:0]               ch;
  logic [midt_pkg::CHAN_MAX-1:0] sample;
  logic                          manual;

  logic stall;
  logic issue;
  logic issue_last;
  logic in_acc;

  assign issue         = busy && !stall;
  assign issue_last    = issue && (ch == LAST_CH);
  assign s_axis_tready = !busy || issue_last;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ch   <= '0;
    end else if (in_acc) begin
      busy <= 1'b1;
      ch   <= '0;
    end else if (issue) begin
      busy <= !issue_last;
      ch   <= issue_last ? '0 : ch + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= s_axis_tdata;
      manual <= s_axis_tuser;
    end
  end

  // state memory, valid bits and write-to-read forwarding
  midt_pkg::chan_state_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] mem_vld;
  midt_pkg::chan_state_t rd_data;
  logic                  rd_vld;
  midt_pkg::chan_state_t byp_data;
  logic                  fwd_hit;

  logic                  wr_en;
  midt_pkg::chan_state_t wr_data;

  // stage one: channel whose state word is arriving from memory
  logic            s1_valid;
  logic [CH_W-1:0] s1_ch;
  logic            s1_now;
  logic            s1_manual;
  logic            s1_last;

  assign wr_en = s1_valid && !stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_ch] <= wr_data;
    end
    if (issue) begin
      rd_data  <= mem[ch];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld  <= '0;
      rd_vld   <= 1'b0;
      fwd_hit  <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_vld[s1_ch] <= 1'b1;
      end
      if (!stall) begin
        s1_valid <= issue;
      end
      if (issue) begin
        rd_vld  <= mem_vld[ch];
        // same entry written this cycle: take the fresh word next cycle
        fwd_hit <= wr_en && (s1_ch == ch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ch     <= ch;
      s1_now    <= sample[ch];
      s1_manual <= manual;
      s1_last   <= (ch == LAST_CH);
    end
  end

  // debounced and clicked vectors
  logic [NUM_CHANNELS-1:0] deb;
  logic [NUM_CHANNELS-1:0] clk_bits;
  logic [NUM_CHANNELS-1:0] deb_next;
  logic [NUM_CHANNELS-1:0] clk_bits_next;

  midt_pkg::chan_state_t       cur;
  logic [midt_pkg::TICK_W-1:0] elapsed_inc;
  logic                        held;

  // read, modify: one channel per cycle while the sweep is not stalled
  always_comb begin
    cur           = fwd_hit ? byp_data : (rd_vld ? rd_data : '0);
    held          = deb[s1_ch];
    elapsed_inc   = (cur.elapsed == midt_pkg::ELAPSED_MAX) ? cur.elapsed
                                                            : cur.elapsed + 16'd1;
    wr_data       = cur;
    deb_next      = deb;
    clk_bits_next = clk_bits;
    if (!cur.running) begin
      // idle channel: start timing on a mismatch
      if (s1_now != held) begin
        wr_data.running = 1'b1;
        wr_data.elapsed = '0;
      end
    end else if (elapsed_inc < debounce_ticks) begin
      wr_data.elapsed = elapsed_inc;
    end else begin
      // timer expired: re-check the sample
      wr_data.running = 1'b0;
      wr_data.elapsed = '0;
      if (s1_now == held) begin
        wr_data.count = 1'b0;
      end else begin
        deb_next[s1_ch] = s1_now;
        if (s1_manual) begin
          if ({1'b0, cur.count} + 2'd1 >= CLICK_N) begin
            clk_bits_next[s1_ch] = !clk_bits[s1_ch];
            wr_data.count        = 1'b0;
          end else begin
            wr_data.count = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deb      <= '0;
      clk_bits <= '0;
    end else if (wr_en) begin
      deb      <= deb_next;
      clk_bits <= clk_bits_next;
    end
  end

  // output register; the sweep waits only when a new result would overwrite
  // a beat that has not been taken
  assign stall = s1_valid && s1_last && m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (wr_en && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_last) begin
      m_axis_tdata <= {16'(clk_bits_next), 16'(deb_next)};
    end
  end

  // a beat taken restarts the sweep at channel zero
  `MIDT_ASSERT(a_accept_starts_sweep, in_acc |=> busy && (ch == '0))
  // the sweep counter stays within the channel range
  `MIDT_ASSERT(a_ch_in_range, busy |-> ch <= LAST_CH)
  // last channel written always loads a result
  `MIDT_ASSERT(a_last_gives_result, wr_en && s1_last |=> m_axis_tvalid)
  // forwarding only fires when the previous write met the same channel
  `MIDT_ASSERT(a_fwd_has_stage, fwd_hit |-> s1_valid)
  // a stall holds the last channel in stage one
  `MIDT_ASSERT(a_stall_holds, stall |=> s1_valid && s1_last && $stable(s1_ch))

endmodule

`default_nettype wire
